FILE: hw/rtl/tfst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame transmitter package
// Shared sizes, opcodes, frame slot map, reset image of the frame table and
// the write-request type passed from the sensor converter to the frame memory.
// ----------------------------------------------------------------------------
package tfst_pkg;

   localparam int FRAME_COUNT = 8;
   localparam int FRAME_BYTES = 7;
   localparam int TABLE_SIZE  = FRAME_COUNT * FRAME_BYTES;

   localparam int ADDR_W = ($clog2(TABLE_SIZE) > 2) ? $clog2(TABLE_SIZE) : 2;
   localparam int ROW_W  = ADDR_W - 1;
   localparam int ROWS   = (TABLE_SIZE + 1) / 2;
   localparam int FIDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int BIDX_W = $clog2(FRAME_BYTES + 1);

   localparam logic [7:0] HEADER_BASE = 8'h11;
   localparam logic [7:0] DEFAULT_B1  = 8'hAF;
   localparam logic [7:0] DEFAULT_B3  = 8'h2D;
   localparam logic [7:0] TEMP_OFFSET = 8'd40;
   localparam logic [15:0] VOLT_OFFSET = 16'd2;

   // Current: (value + 114.875) * 1.441. The offset is 919/8 exactly and the
   // gain is 1.441 in Q13, so the product is shifted down by 3 + 13 bits.
   localparam int CUR_OFFSET_X8 = 919;
   localparam int CUR_GAIN_Q13  = 11805;

   // Divide by 10 as a multiply by ceil(2^19 / 10); exact for 16-bit values.
   localparam int RPM_RECIP = 52429;
   localparam int RPM_SHIFT = 19;

   typedef enum logic [3:0] {
      OP_ADDR_READ = 4'd0,
      OP_BYTE_ACK  = 4'd1,
      OP_DONE      = 4'd2,
      OP_VOLTAGE   = 4'd3,
      OP_CURRENT   = 4'd4,
      OP_FUEL      = 4'd5,
      OP_ALTITUDE  = 4'd6,
      OP_SPEED     = 4'd7,
      OP_RPM       = 4'd8,
      OP_TEMP      = 4'd9
   } opcode_type;

   // Slot map as (frame, byte).
   localparam int VOLT_F = 7, VOLT_B = 1;
   localparam int CUR_F  = 7, CUR_B  = 3;
   localparam int FUEL_F = 4, FUEL_B = 1;
   localparam int ALT_F  = 3, ALT_B  = 3;
   localparam int SPD_F  = 3, SPD_B  = 1;
   localparam int RPM0_F = 4, RPM0_B = 2;
   localparam int RPM1_F = 4, RPM1_B = 4;
   localparam int TMP0_F = 3, TMP0_B = 5;
   localparam int TMP1_F = 2, TMP1_B = 5;
   localparam int TMP2_F = 6, TMP2_B = 4;
   localparam int TMP3_F = 6, TMP3_B = 5;

   typedef logic [TABLE_SIZE-1:0][7:0] table_type;

   typedef struct packed {
      logic              lo_en;
      logic [ADDR_W-1:0] lo_addr;
      logic [7:0]        lo_data;
      logic              hi_en;
      logic [ADDR_W-1:0] hi_addr;
      logic [7:0]        hi_data;
   } wr_req_type;

   function automatic logic slot_ok(input int f, input int b);
      return (f < FRAME_COUNT) && (b < FRAME_BYTES);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_addr(input int f, input int b);
      return ADDR_W'(f * FRAME_BYTES + b);
   endfunction

   function automatic wr_req_type put_slot(input int f, input int b, input logic [7:0] data);
      wr_req_type r;
      r         = '0;
      r.lo_en   = slot_ok(f, b);
      r.lo_addr = slot_addr(f, b);
      r.lo_data = data;
      return r;
   endfunction

   function automatic wr_req_type put_pair(input int f, input int b, input logic [15:0] data);
      wr_req_type r;
      r         = put_slot(f, b, data[7:0]);
      r.hi_en   = slot_ok(f, b + 1);
      r.hi_addr = slot_addr(f, b + 1);
      r.hi_data = data[15:8];
      return r;
   endfunction

   function automatic table_type build_init();
      table_type t;
      t = '0;
      for (int f = 0; f < FRAME_COUNT; f++) begin
         t[f * FRAME_BYTES]                   = HEADER_BASE + 8'(f);
         t[f * FRAME_BYTES + FRAME_BYTES - 1] = HEADER_BASE + 8'(f);
      end
      if (slot_ok(0, 1)) begin
         t[1] = DEFAULT_B1;
      end
      if (slot_ok(0, 3)) begin
         t[3] = DEFAULT_B3;
      end
      return t;
   endfunction

   localparam table_type INIT_TABLE = build_init();

endpackage
`default_nettype wire

FILE: hw/rtl/telemetry_frame_slave_transmitter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Telemetry frame slave transmitter
// Serves eight seven-byte telemetry frames byte by byte to a bus master and
// packs converted sensor values into their frame slots.
// ----------------------------------------------------------------------------
// Usage:
//   A transfer enters on the request channel (req_opcode, req_value,
//   req_channel) at a clock edge where start is high and busy is low. busy is
//   low at all times outside reset, so a new transfer may enter every cycle.
//   Every request gives exactly one response: rsp_strobe is high for one
//   cycle with rsp_tx_byte, rsp_more_follows and rsp_byte_valid. Byte reads
//   return the current frame byte; all other opcodes return all zeros.
//   An accepted transfer passes the input register, then the table read and
//   sensor conversion, whose outcome lands in the response and memory
//   registers that drive the strobe cycle. Throughput is one transfer per
//   cycle; the single read port and the two-bank write port of the frame
//   table each serve one event a cycle. The receiver cannot hold responses
//   off, so nothing ever backs up.
//   Reset clears the frame and byte indices, the response flags and all table
//   valid bits, so every table byte reads its reset-image value (header,
//   default or zero) until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
module telemetry_frame_slave_transmitter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [3:0]  req_opcode,
   input  wire logic [15:0] req_value,
   input  wire logic [1:0]  req_channel,
   output      logic        rsp_strobe,
   output      logic [7:0]  rsp_tx_byte,
   output      logic        rsp_more_follows,
   output      logic        rsp_byte_valid
);
   import tfst_pkg::*;

   // Input register.
   logic        req_valid_ff;
   logic [3:0]  req_opcode_ff;
   logic [15:0] req_value_ff;
   logic [1:0]  req_channel_ff;

   // Frame pointer state.
   logic [FIDX_W-1:0] frame_idx_ff, frame_idx_in;
   logic [BIDX_W-1:0] byte_idx_ff, byte_idx_in;

   // Response register.
   logic rsp_strobe_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_more_ff, rsp_more_in;

   logic              is_read, is_ack, is_done;
   logic [BIDX_W-1:0] eff_byte;
   logic              hit;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   wr_req_type        wr;

   // Busy only while reset is applied.
   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      req_opcode_ff  <= req_opcode;
      req_value_ff   <= req_value;
      req_channel_ff <= req_channel;
   end

   // An addressed read restarts the frame at byte zero and sends it at once;
   // an acknowledged byte sends the byte under the pointer if any is left.
   always_comb begin
      is_read  = req_valid_ff && (opcode_type'(req_opcode_ff) == OP_ADDR_READ);
      is_ack   = req_valid_ff && (opcode_type'(req_opcode_ff) == OP_BYTE_ACK);
      is_done  = req_valid_ff && (opcode_type'(req_opcode_ff) == OP_DONE);
      eff_byte = is_read ? '0 : byte_idx_ff;
      hit      = (is_read || is_ack) && (eff_byte < BIDX_W'(FRAME_BYTES));
      rd_addr  = ADDR_W'(int'(frame_idx_ff) * FRAME_BYTES + int'(eff_byte));

      byte_idx_in  = hit ? (eff_byte + 1'b1) : byte_idx_ff;
      rsp_valid_in = hit;
      rsp_more_in  = hit && (({1'b0, eff_byte} + 1'b1) < (BIDX_W + 1)'(FRAME_BYTES));

      frame_idx_in = frame_idx_ff;
      if (is_done) begin
         frame_idx_in = (frame_idx_ff == FIDX_W'(FRAME_COUNT - 1)) ? '0
                                                                   : frame_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_idx_ff  <= '0;
         byte_idx_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_more_ff   <= 1'b0;
      end else begin
         frame_idx_ff  <= frame_idx_in;
         byte_idx_ff   <= byte_idx_in;
         rsp_strobe_ff <= req_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_more_ff   <= rsp_more_in;
      end
   end

   tfst_convert u_convert (
      .req_valid (req_valid_ff),
      .opcode    (req_opcode_ff),
      .value     (req_value_ff),
      .channel   (req_channel_ff),
      .wr        (wr)
   );

   tfst_frame_mem u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The table read lands together with the response flags; non-read and
   // past-the-end transfers send a zero byte.
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_tx_byte      = rsp_valid_ff ? rd_data : 8'h00;
   assign rsp_more_follows = rsp_more_ff;
   assign rsp_byte_valid   = rsp_valid_ff;

`ifndef SYNTHESIS
   // Every accepted transfer gives a response strobe after the input and response registers.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("response strobe missing after accepted request");

   // The byte pointer never runs past the end of a frame.
   a_byte_idx_range: assert property (@(posedge clock) disable iff (reset)
      byte_idx_ff <= BIDX_W'(FRAME_BYTES))
      else $error("byte index beyond frame end");

   // The frame pointer stays inside the table.
   a_frame_idx_range: assert property (@(posedge clock) disable iff (reset)
      int'(frame_idx_ff) < FRAME_COUNT)
      else $error("frame index beyond frame count");

   // More-follows is only ever raised on a real byte.
   a_more_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_more_follows |-> (rsp_byte_valid && rsp_strobe))
      else $error("more_follows without a valid byte");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/tfst_convert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor value converter
// Turns one sensor write event into at most two byte writes to the frame table.
// ----------------------------------------------------------------------------
module tfst_convert (
   input  wire logic                 req_valid,
   input  wire logic [3:0]           opcode,
   input  wire logic [15:0]          value,
   input  wire logic [1:0]           channel,
   output      tfst_pkg::wr_req_type wr
);
   import tfst_pkg::*;

   logic [19:0] cur_sum;
   logic [33:0] cur_prod;
   logic [17:0] cur_q;
   logic [15:0] cur_sat;
   logic [31:0] rpm_prod;
   logic [15:0] rpm_q;
   logic [15:0] volt;
   logic [7:0]  temp;

   always_comb begin
      cur_sum  = 20'({value, 3'b000}) + 20'(CUR_OFFSET_X8);
      cur_prod = 34'(cur_sum) * 34'(CUR_GAIN_Q13);
      cur_q    = cur_prod[33:16];
      // Saturate at the top of the 16-bit slot.
      cur_sat  = (|cur_q[17:16]) ? 16'hFFFF : cur_q[15:0];
      rpm_prod = 32'(value) * 32'(RPM_RECIP);
      rpm_q    = 16'(rpm_prod[31:RPM_SHIFT]);
      volt     = value - VOLT_OFFSET;
      temp     = value[7:0] + TEMP_OFFSET;
   end

   always_comb begin
      wr = '0;
      if (req_valid) begin
         unique case (opcode_type'(opcode))
            OP_VOLTAGE:  wr = put_pair(VOLT_F, VOLT_B, volt);
            OP_CURRENT:  wr = put_pair(CUR_F, CUR_B, cur_sat);
            OP_FUEL:     wr = put_slot(FUEL_F, FUEL_B, value[7:0]);
            OP_ALTITUDE: wr = put_pair(ALT_F, ALT_B, value);
            OP_SPEED:    wr = put_pair(SPD_F, SPD_B, value);
            OP_RPM: begin
               if (channel == 2'd0) begin
                  wr = put_pair(RPM0_F, RPM0_B, rpm_q);
               end else if (channel == 2'd1) begin
                  wr = put_pair(RPM1_F, RPM1_B, rpm_q);
               end
            end
            OP_TEMP: begin
               unique case (channel)
                  2'd0:    wr = put_slot(TMP0_F, TMP0_B, temp);
                  2'd1:    wr = put_slot(TMP1_F, TMP1_B, temp);
                  2'd2:    wr = put_slot(TMP2_F, TMP2_B, temp);
                  default: wr = put_slot(TMP3_F, TMP3_B, temp);
               endcase
            end
            default: wr = '0;
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/tfst_frame_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame table memory
// Two banks split by the lowest address bit, so both bytes of a 16-bit pair
// are written in the same cycle. Per-entry valid bits stand in for the reset
// image until an entry is first written. Read data is registered.
// ----------------------------------------------------------------------------
module tfst_frame_mem (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tfst_pkg::wr_req_type        wr,
   input  wire logic [tfst_pkg::ADDR_W-1:0] rd_addr,
   output      logic [7:0]                  rd_data
);
   import tfst_pkg::*;

   logic [7:0]      bank0_mem [ROWS];
   logic [7:0]      bank1_mem [ROWS];
   logic [ROWS-1:0] bank0_vld_ff;
   logic [ROWS-1:0] bank1_vld_ff;

   logic             we0, we1;
   logic [ROW_W-1:0] wrow0, wrow1;
   logic [7:0]       wdata0, wdata1;

   logic [7:0] rd0_ff, rd1_ff, init_ff;
   logic       vld0_ff, vld1_ff, bank_sel_ff;

   // The two bytes of a pair sit at consecutive addresses, so they never
   // land in the same bank.
   always_comb begin
      we0 = 1'b0; wrow0 = wr.lo_addr[ADDR_W-1:1]; wdata0 = wr.lo_data;
      we1 = 1'b0; wrow1 = wr.lo_addr[ADDR_W-1:1]; wdata1 = wr.lo_data;
      priority if (wr.lo_en && !wr.lo_addr[0]) begin
         we0 = 1'b1;
      end else if (wr.hi_en && !wr.hi_addr[0]) begin
         we0 = 1'b1; wrow0 = wr.hi_addr[ADDR_W-1:1]; wdata0 = wr.hi_data;
      end else begin
         we0 = 1'b0;
      end
      priority if (wr.lo_en && wr.lo_addr[0]) begin
         we1 = 1'b1;
      end else if (wr.hi_en && wr.hi_addr[0]) begin
         we1 = 1'b1; wrow1 = wr.hi_addr[ADDR_W-1:1]; wdata1 = wr.hi_data;
      end else begin
         we1 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         bank0_mem[wrow0] <= wdata0;
      end
      if (we1) begin
         bank1_mem[wrow1] <= wdata1;
      end
      rd0_ff      <= bank0_mem[rd_addr[ADDR_W-1:1]];
      rd1_ff      <= bank1_mem[rd_addr[ADDR_W-1:1]];
      vld0_ff     <= bank0_vld_ff[rd_addr[ADDR_W-1:1]];
      vld1_ff     <= bank1_vld_ff[rd_addr[ADDR_W-1:1]];
      init_ff     <= INIT_TABLE[rd_addr];
      bank_sel_ff <= rd_addr[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank0_vld_ff <= '0;
         bank1_vld_ff <= '0;
      end else begin
         if (we0) begin
            bank0_vld_ff[wrow0] <= 1'b1;
         end
         if (we1) begin
            bank1_vld_ff[wrow1] <= 1'b1;
         end
      end
   end

   always_comb begin
      if (bank_sel_ff) begin
         rd_data = vld1_ff ? rd1_ff : init_ff;
      end else begin
         rd_data = vld0_ff ? rd0_ff : init_ff;
      end
   end

endmodule
`default_nettype wire
